[sv/hsv_pkg.sv]
// Package for the HSV to RGB converter: field widths, hue constants, sector codes.
// Depends on nothing; every other file of the block uses it.
package hsv_pkg;

  // Port field widths
  localparam int HUE_W     = 18;
  localparam int COMP_IN_W = 16;
  localparam int COMP_OUT_W = 15;

  // Default number of fraction bits of saturation, value and the outputs
  localparam int DEF_COMPONENT_FRAC_BITS = 14;

  // Hue scale: 64 counts per degree
  localparam int HUE_FULL_TURN   = 23040;
  localparam int HUE_SECTOR      = 3840;
  localparam int HUE_HALF_SECTOR = 1920;
  // Six full turns, so that any 18-bit hue becomes non-negative
  localparam int HUE_BIAS        = 6 * HUE_FULL_TURN;

  // Sixty-degree sectors of the hue circle
  localparam logic [2:0] SEC_RED_YELLOW    = 3'd0;
  localparam logic [2:0] SEC_YELLOW_GREEN  = 3'd1;
  localparam logic [2:0] SEC_GREEN_CYAN    = 3'd2;
  localparam logic [2:0] SEC_CYAN_BLUE     = 3'd3;
  localparam logic [2:0] SEC_BLUE_MAGENTA  = 3'd4;
  localparam logic [2:0] SEC_MAGENTA_RED   = 3'd5;
  localparam logic [2:0] SECTORS           = 3'd6;

endpackage

[sv/hsv_if.sv]
// Stream interfaces of the HSV to RGB converter: HSV input and RGB output channels.
// Depends on hsv_pkg for the field widths.
interface hsv_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [hsv_pkg::HUE_W-1:0]         hue;
  logic signed [hsv_pkg::COMP_IN_W-1:0]     saturation;
  logic signed [hsv_pkg::COMP_IN_W-1:0]     brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface rgb_out_if;
  logic                                valid;
  logic                                ready;
  logic [hsv_pkg::COMP_OUT_W-1:0]      red;
  logic [hsv_pkg::COMP_OUT_W-1:0]      green;
  logic [hsv_pkg::COMP_OUT_W-1:0]      blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

[sv/hsv_to_rgb_converter.sv]
// HSV to RGB converter top level: six-stage pipeline, one pixel per clock unless rgb stalls.
// Depends on hsv_pkg and on the hsv_in_if / rgb_out_if stream interfaces.

// A pixel enters on the hsv channel and its color leaves on the rgb channel from
// the output register; the pipeline accepts one transaction every clock unless
// the rgb side stalls, and has no state between pixels. Hue is in degrees with
// 6 fraction bits and wraps into 0..360 for any value, negative hues included.
// Saturation and brightness are clamped to 0..1.0
// (1 << COMPONENT_FRAC_BITS) before use; red, green and blue come out in the
// same format. Throughput is one transaction per cycle while rgb takes results,
// with one register stage each for the three multiply-by-reciprocal steps
// (hue / 3840, sector mod 6, secondary / 3840), the two products of the
// datapath and the sector routing into the output register. When the rgb side
// stalls, the whole pipeline holds, and hsv.ready drops in the same cycle.
module hsv_to_rgb_converter #(
  parameter int COMPONENT_FRAC_BITS = hsv_pkg::DEF_COMPONENT_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst,
  hsv_in_if.sink     hsv,
  rgb_out_if.source  rgb
);
  import hsv_pkg::*;

  localparam int F    = COMPONENT_FRAC_BITS;
  localparam int CW   = F + 1;            // clamped component, 0..1 << F
  localparam int PW   = 2 * CW;           // v * s
  localparam int KW   = 12;               // position in sector, 0..3840
  localparam int CKW  = CW + KW;          // c * k
  localparam int UW   = CW + 4;           // (c * k + half sector) >> 8
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_15    = (1 << RECIP_SHIFT) / 15 + 1;
  localparam int RW   = 21;               // width of RECIP_15
  localparam int MQW  = UW + RW;
  localparam int ONE  = 1 << F;
  localparam int HALF = 1 << (F - 1);

  // Pipeline advances unless the output register holds a result nobody takes
  logic [6:1] vld;
  logic       advance;

  assign advance   = !vld[6] || rgb.ready;
  assign hsv.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[5:1], hsv.valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: clamp s and v, bias the hue non-negative, estimate hue / 3840
  // ---------------------------------------------------------------------------
  int          s_int, v_int;
  logic [CW-1:0] s_cl, v_cl;
  logic [18:0] hp_c;
  logic [22:0] q_est;

  always_comb begin
    s_int = int'(hsv.saturation);
    v_int = int'(hsv.brightness);
    if (s_int < 0)        s_cl = '0;
    else if (s_int > ONE) s_cl = CW'(ONE);
    else                  s_cl = CW'(s_int);
    if (v_int < 0)        v_cl = '0;
    else if (v_int > ONE) v_cl = CW'(ONE);
    else                  v_cl = CW'(v_int);
    hp_c  = 19'(int'(hsv.hue) + HUE_BIAS);
    // floor(hp / 3840) = floor((hp >> 8) / 15), 15 by reciprocal 2185 / 2^15
    q_est = 23'(hp_c[18:8]) * 23'(2185);
  end

  logic [CW-1:0] s1, v1;
  logic [18:0]   hp1;
  logic [6:0]    q1;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1  <= s_cl;
      v1  <= v_cl;
      hp1 <= hp_c;
      q1  <= q_est[21:15];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: remainder in the sector with one correction step; chroma product
  // ---------------------------------------------------------------------------
  logic [18:0] rem_t;
  logic [6:0]  q_fix;
  logic [KW-1:0] r_fix;

  always_comb begin
    rem_t = hp1 - 19'(q1) * 19'(HUE_SECTOR);
    if (rem_t >= 19'(HUE_SECTOR)) begin
      q_fix = q1 + 7'd1;
      r_fix = KW'(rem_t - 19'(HUE_SECTOR));
    end else begin
      q_fix = q1;
      r_fix = KW'(rem_t);
    end
  end

  logic [PW-1:0] vs2;
  logic [CW-1:0] v2;
  logic [6:0]    q2;
  logic [KW-1:0] r2;

  always_ff @(posedge clk) begin
    if (advance) begin
      vs2 <= PW'(v1) * PW'(s1);
      v2  <= v1;
      q2  <= q_fix;
      r2  <= r_fix;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: round chroma, sector = q mod 6, mirror the position on odd sectors
  // ---------------------------------------------------------------------------
  logic [PW:0]   c_sum;
  logic [CW-1:0] c_rnd;
  logic [11:0]   q6_mul;
  logic [6:0]    sec_t;
  logic [2:0]    sec_c;
  logic [KW-1:0] k_c;

  always_comb begin
    c_sum  = (PW+1)'(vs2) + (PW+1)'(HALF);
    c_rnd  = CW'(c_sum >> F);
    // q / 6 by reciprocal 43 / 256, exact for q up to 70
    q6_mul = 12'(q2) * 12'd43;
    sec_t  = q2 - 7'(q6_mul[11:8]) * 7'(SECTORS);
    if (sec_t >= 7'(SECTORS)) sec_c = 3'(sec_t - 7'(SECTORS));
    else                      sec_c = sec_t[2:0];
    k_c = sec_c[0] ? KW'(HUE_SECTOR) - r2 : r2;
  end

  logic [CW-1:0] c3, v3;
  logic [2:0]    sec3;
  logic [KW-1:0] k3;

  always_ff @(posedge clk) begin
    if (advance) begin
      c3   <= c_rnd;
      v3   <= v2;
      sec3 <= sec_c;
      k3   <= k_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: secondary product c * k and offset m = v - c
  // ---------------------------------------------------------------------------
  logic [CKW-1:0] ck4;
  logic [CW-1:0]  m4, v4;
  logic [2:0]     sec4;

  always_ff @(posedge clk) begin
    if (advance) begin
      ck4  <= CKW'(c3) * CKW'(k3);
      m4   <= v3 - c3;
      v4   <= v3;
      sec4 <= sec3;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: (c*k + 1920) / 3840 as ((c*k + 1920) >> 8) times reciprocal of 15
  // ---------------------------------------------------------------------------
  logic [CKW-1:0] ck_rnd;
  logic [UW-1:0]  u5;

  always_comb begin
    ck_rnd = ck4 + CKW'(HUE_HALF_SECTOR);
    u5     = UW'(ck_rnd >> 8);
  end

  logic [MQW-1:0] mq5;
  logic [CW-1:0]  m5, v5;
  logic [2:0]     sec5;

  always_ff @(posedge clk) begin
    if (advance) begin
      mq5  <= MQW'(u5) * MQW'(RECIP_15);
      m5   <= m4;
      v5   <= v4;
      sec5 <= sec4;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: finish x, route hi / mid / low by sector into the output register
  // ---------------------------------------------------------------------------
  logic [CW-1:0] x6, mid6;
  logic [CW-1:0] red_next, green_next, blue_next;

  always_comb begin
    x6   = CW'(mq5 >> RECIP_SHIFT);
    mid6 = x6 + m5;
    // hi = c + m is the clamped value itself
    case (sec5)
      SEC_RED_YELLOW: begin
        red_next = v5;   green_next = mid6; blue_next = m5;
      end
      SEC_YELLOW_GREEN: begin
        red_next = mid6; green_next = v5;   blue_next = m5;
      end
      SEC_GREEN_CYAN: begin
        red_next = m5;   green_next = v5;   blue_next = mid6;
      end
      SEC_CYAN_BLUE: begin
        red_next = m5;   green_next = mid6; blue_next = v5;
      end
      SEC_BLUE_MAGENTA: begin
        red_next = mid6; green_next = m5;   blue_next = v5;
      end
      default: begin
        red_next = v5;   green_next = m5;   blue_next = mid6;
      end
    endcase
  end

  logic [COMP_OUT_W-1:0] red, green, blue;

  always_ff @(posedge clk) begin
    if (advance) begin
      red   <= COMP_OUT_W'(red_next);
      green <= COMP_OUT_W'(green_next);
      blue  <= COMP_OUT_W'(blue_next);
    end
  end

  assign rgb.valid = vld[6];
  assign rgb.red   = red;
  assign rgb.green = green;
  assign rgb.blue  = blue;

endmodule
